@@ rtl/imgsc_pkg.sv @@
// Shared types, constants and the channel blend function of the ARGB frame scaler.
// Depends on nothing; imported by imgsc_dp, imgsc_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none

package imgsc_pkg;

  localparam int unsigned MAX_SRC_DIM_D = 128;
  localparam int unsigned MAX_DST_DIM_D = 4096;
  localparam int unsigned FRAC_W        = 16;
  localparam int unsigned PADDR_W       = 5;

  localparam logic [2:0] REG_SRC_WIDTH      = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT     = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH      = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT     = 3'd3;
  localparam logic [2:0] REG_ANTI_ALIAS     = 3'd4;
  localparam logic [2:0] REG_OUTSIDE_COLOUR = 3'd5;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic [1:0] DIV_DERIVE = 2'd0;
  localparam logic [1:0] DIV_RX     = 2'd1;
  localparam logic [1:0] DIV_RY     = 2'd2;

  localparam logic [1:0] RES_ERR     = 2'd0;
  localparam logic [1:0] RES_OUTSIDE = 2'd1;
  localparam logic [1:0] RES_NEAR    = 2'd2;
  localparam logic [1:0] RES_BLEND   = 2'd3;

  typedef struct packed {
    logic [7:0]  src_width;
    logic [7:0]  src_height;
    logic [11:0] dst_width;
    logic [11:0] dst_height;
    logic        anti_alias;
    logic [31:0] outside_colour;
  } cfg_t;

  typedef struct packed {
    logic       accept;
    logic       div_start;
    logic [1:0] div_sel;
    logic       ld_derive;
    logic       ld_rx;
    logic       ld_ry;
    logic       mul;
    logic       rd;
    logic [1:0] rd_idx;
    logic       cap;
    logic [1:0] cap_idx;
    logic       mix1;
    logic       res_ld;
    logic [1:0] res_sel;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic both_zero;
    logic need_derive;
    logic blend;
    logic div_done;
    logic outside_dst;
  } sts_t;

  // bg + (fg - bg) * level / 255 per channel, quotient truncated toward zero
  function automatic logic [31:0] mix(input logic [31:0] fg, input logic [31:0] bg,
                                      input logic [7:0] level);
    logic [31:0]        res;
    logic signed [8:0]  d;
    logic signed [17:0] p;
    logic [15:0]        m;
    logic [16:0]        q;
    logic [7:0]         b;
    res = '0;
    for (int ch = 0; ch < 4; ch++) begin
      b = bg[ch*8 +: 8];
      d = $signed({1'b0, fg[ch*8 +: 8]}) - $signed({1'b0, b});
      p = d * $signed({1'b0, level});
      m = p[17] ? 16'(-p) : 16'(p);
      q = (17'(m) + 17'(m >> 8) + 17'd1) >> 8;
      res[ch*8 +: 8] = p[17] ? (b - q[7:0]) : (b + q[7:0]);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/imgsc_ram.sv @@
// Generic single-port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module imgsc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ rtl/imgsc_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module imgsc_div #(
  parameter int unsigned NUM_W = 24,
  parameter int unsigned DEN_W = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo,
  output logic                  done
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsr;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    shifted  = {rem, acc[NUM_W-1]};
    diff     = shifted - {1'b0, dsr};
    ge       = shifted >= {1'b0, dsr};
    rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= num;
      rem <= '0;
      dsr <= den;
    end else if (busy) begin
      acc <= {acc[NUM_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quo = acc;

endmodule

`default_nettype wire

@@ rtl/imgsc_dp.sv @@
// Datapath: frame store, size and ratio registers, coordinate products, blend stages.
// Depends on imgsc_pkg, imgsc_ram and imgsc_div.
`timescale 1ns / 1ps
`default_nettype none

module imgsc_dp
  import imgsc_pkg::*;
#(
  parameter int unsigned MAX_SRC_DIM = MAX_SRC_DIM_D,
  parameter int unsigned MAX_DST_DIM = MAX_DST_DIM_D
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic        op,
  input  wire logic [6:0]  src_x,
  input  wire logic [6:0]  src_y,
  input  wire logic [31:0] pixel_in,
  input  wire logic [11:0] dst_x,
  input  wire logic [11:0] dst_y,
  output logic      [31:0] pixel_out,
  output logic             size_error
);

  localparam int unsigned DIM_W  = $clog2(MAX_SRC_DIM + 1);
  localparam int unsigned X_W    = $clog2(MAX_SRC_DIM);
  localparam int unsigned DEPTH  = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned DD_W   = $clog2(MAX_DST_DIM);
  localparam int unsigned NUM_W  = DIM_W + FRAC_W;
  localparam int unsigned DS_W   = (DD_W > DIM_W) ? DD_W : DIM_W;
  localparam int unsigned CMP_W  = (DD_W > 12) ? DD_W : 12;
  localparam int unsigned PX_W   = 12 + NUM_W;
  localparam int unsigned NX_W   = PX_W - FRAC_W + 1;

  function automatic logic [DIM_W-1:0] clamp_src(input logic [7:0] v);
    if (v == 8'd0) begin
      return DIM_W'(1);
    end else if (32'(v) > MAX_SRC_DIM) begin
      return DIM_W'(MAX_SRC_DIM);
    end
    return DIM_W'(v);
  endfunction

  function automatic logic [DD_W-1:0] clamp_dst(input logic [NUM_W-1:0] v);
    if (v == '0) begin
      return DD_W'(1);
    end else if (v > NUM_W'(MAX_DST_DIM - 1)) begin
      return DD_W'(MAX_DST_DIM - 1);
    end
    return DD_W'(v);
  endfunction

  logic [DIM_W-1:0]  sw;
  logic [DIM_W-1:0]  sh;
  logic [DD_W-1:0]   dwc;
  logic [DD_W-1:0]   dhc;
  logic [DD_W-1:0]   derived;
  logic [NUM_W-1:0]  rx;
  logic [NUM_W-1:0]  ry;
  logic [11:0]       dx;
  logic [11:0]       dy;
  logic [PX_W-1:0]   px;
  logic [PX_W-1:0]   py;
  logic [31:0]       nb [4];
  logic              rd_out;
  logic [31:0]       c1;
  logic [31:0]       c2;
  logic [31:0]       res_pix;
  logic              res_err;
  logic              blend;
  logic [NUM_W-1:0]  div_num;
  logic [DS_W-1:0]   div_den;
  logic [NUM_W-1:0]  div_quo;
  logic              div_done;
  logic [DIM_W-1:0]  num_w;
  logic [DIM_W-1:0]  num_h;
  logic [NX_W-1:0]   nx;
  logic [NX_W-1:0]   ny;
  logic              n_out;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic              st_in;
  logic              we;
  logic [ADDR_W-1:0] ram_addr;
  logic [31:0]       rdata;
  logic [7:0]        lx;
  logic [7:0]        ly;

  always_comb begin
    sw    = clamp_src(cfg.src_width);
    sh    = clamp_src(cfg.src_height);
    dwc   = (cfg.dst_width == 12'd0) ? derived : clamp_dst(NUM_W'(cfg.dst_width));
    dhc   = (cfg.dst_height == 12'd0) ? derived : clamp_dst(NUM_W'(cfg.dst_height));
    blend = cfg.anti_alias &&
            ((DS_W'(dwc) > DS_W'(sw) - DS_W'(1)) || (DS_W'(dhc) > DS_W'(sh) - DS_W'(1)));
    num_w = blend ? (sw - DIM_W'(1)) : sw;
    num_h = blend ? (sh - DIM_W'(1)) : sh;

    sts.both_zero   = (cfg.dst_width == 12'd0) && (cfg.dst_height == 12'd0);
    sts.need_derive = (cfg.dst_width == 12'd0) != (cfg.dst_height == 12'd0);
    sts.blend       = blend;
    sts.div_done    = div_done;
    sts.outside_dst = (CMP_W'(dx) >= CMP_W'(dwc)) || (CMP_W'(dy) >= CMP_W'(dhc));

    unique case (cmd.div_sel)
      DIV_DERIVE: begin
        if (cfg.dst_height == 12'd0) begin
          div_num = NUM_W'(cfg.dst_width) * NUM_W'(sh);
          div_den = DS_W'(sw);
        end else begin
          div_num = NUM_W'(cfg.dst_height) * NUM_W'(sw);
          div_den = DS_W'(sh);
        end
      end
      DIV_RX: begin
        div_num = {num_w, FRAC_W'(0)};
        div_den = DS_W'(dwc);
      end
      DIV_RY: begin
        div_num = {num_h, FRAC_W'(0)};
        div_den = DS_W'(dhc);
      end
      default: begin
        div_num = '0;
        div_den = DS_W'(1);
      end
    endcase
  end

  imgsc_div #(
    .NUM_W(NUM_W),
    .DEN_W(DS_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .quo  (div_quo),
    .done (div_done)
  );

  always_comb begin
    nx    = NX_W'(px[PX_W-1:FRAC_W]) + NX_W'(cmd.rd_idx[0]);
    ny    = NX_W'(py[PX_W-1:FRAC_W]) + NX_W'(cmd.rd_idx[1]);
    n_out = (nx >= NX_W'(sw)) || (ny >= NX_W'(sh));
    raddr = ADDR_W'(ny[X_W-1:0]) * ADDR_W'(MAX_SRC_DIM) + ADDR_W'(nx[X_W-1:0]);
    st_in = (int'(src_x) < int'(MAX_SRC_DIM)) && (int'(src_y) < int'(MAX_SRC_DIM));
    waddr = ADDR_W'(src_y) * ADDR_W'(MAX_SRC_DIM) + ADDR_W'(src_x);
    we    = cmd.accept && (op == OP_STORE) && st_in;
    ram_addr = we ? waddr : raddr;
    lx    = ~px[FRAC_W-1 -: 8];
    ly    = ~py[FRAC_W-1 -: 8];
  end

  imgsc_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .addr (ram_addr),
    .wdata(pixel_in),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dx <= dst_x;
      dy <= dst_y;
    end
    if (cmd.ld_derive) begin
      derived <= clamp_dst(div_quo);
    end
    if (cmd.ld_rx) begin
      rx <= div_quo;
    end
    if (cmd.ld_ry) begin
      ry <= div_quo;
    end
    if (cmd.mul) begin
      px <= PX_W'(dx) * PX_W'(rx);
      py <= PX_W'(dy) * PX_W'(ry);
    end
    if (cmd.rd) begin
      rd_out <= n_out;
    end
    if (cmd.cap) begin
      nb[cmd.cap_idx] <= rd_out ? cfg.outside_colour : rdata;
    end
    if (cmd.mix1) begin
      c1 <= mix(nb[0], nb[1], lx);
      c2 <= mix(nb[2], nb[3], lx);
    end
    if (cmd.res_ld) begin
      case (cmd.res_sel)
        RES_ERR: begin
          res_pix <= '0;
          res_err <= 1'b1;
        end
        RES_OUTSIDE: begin
          res_pix <= cfg.outside_colour;
          res_err <= 1'b0;
        end
        RES_NEAR: begin
          res_pix <= nb[0];
          res_err <= 1'b0;
        end
        default: begin
          res_pix <= mix(c1, c2, ly);
          res_err <= 1'b0;
        end
      endcase
    end
    if (cmd.out_ld) begin
      pixel_out  <= res_pix;
      size_error <= res_err;
    end
  end

endmodule

`default_nettype wire

@@ rtl/imgsc_ctrl.sv @@
// Controller: sequences ratio division, coordinate products, store reads and blending.
// Depends on imgsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imgsc_ctrl
  import imgsc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic op,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire logic cfg_wr,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DERIVE = 4'd1;
  localparam logic [3:0] S_RX     = 4'd2;
  localparam logic [3:0] S_RY     = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_RD     = 4'd5;
  localparam logic [3:0] S_MIX1   = 4'd6;
  localparam logic [3:0] S_MIX2   = 4'd7;
  localparam logic [3:0] S_NEAR   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [2:0] cnt;
  logic [2:0] cnt_next;
  logic [2:0] n_rd;
  logic       started;
  logic       started_next;
  logic       stale;
  logic       stale_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cnt_next       = cnt;
    started_next   = started;
    stale_next     = stale;
    n_rd           = sts.blend ? 3'd4 : 3'd1;
    cmd.accept     = in_valid && in_ready;

    unique case (state) inside
      S_IDLE: begin
        if (cmd.accept && (op == OP_FETCH)) begin
          if (sts.both_zero) begin
            cmd.res_ld  = 1'b1;
            cmd.res_sel = RES_ERR;
            state_next  = S_OUT;
          end else if (stale) begin
            state_next = sts.need_derive ? S_DERIVE : S_RX;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_DERIVE, S_RX, S_RY: begin
        cmd.div_sel = (state == S_DERIVE) ? DIV_DERIVE :
                      (state == S_RX)     ? DIV_RX : DIV_RY;
        if (!started) begin
          cmd.div_start = 1'b1;
          started_next  = 1'b1;
        end else if (sts.div_done) begin
          started_next = 1'b0;
          if (state == S_DERIVE) begin
            cmd.ld_derive = 1'b1;
            state_next    = S_RX;
          end else if (state == S_RX) begin
            cmd.ld_rx  = 1'b1;
            state_next = S_RY;
          end else begin
            cmd.ld_ry  = 1'b1;
            stale_next = 1'b0;
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (sts.outside_dst) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = RES_OUTSIDE;
          state_next  = S_OUT;
        end else begin
          cnt_next   = 3'd0;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd      = cnt < n_rd;
        cmd.rd_idx  = cnt[1:0];
        cmd.cap     = cnt != 3'd0;
        cmd.cap_idx = 2'(cnt - 3'd1);
        if (cnt >= n_rd) begin
          cnt_next   = 3'd0;
          state_next = sts.blend ? S_MIX1 : S_NEAR;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      S_MIX1: begin
        cmd.mix1   = 1'b1;
        state_next = S_MIX2;
      end
      S_MIX2: begin
        cmd.res_ld  = 1'b1;
        cmd.res_sel = RES_BLEND;
        state_next  = S_OUT;
      end
      S_NEAR: begin
        cmd.res_ld  = 1'b1;
        cmd.res_sel = RES_NEAR;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (cfg_wr) begin
      stale_next = 1'b1;
    end

    if (cmd.out_ld) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= 3'd0;
      started   <= 1'b0;
      stale     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      started   <= started_next;
      stale     <= stale_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == S_DERIVE || state == S_RX || state == S_RY))
    else $error("divider finished outside a ratio state");

  a_cfg_stale: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> stale)
    else $error("ratios not marked stale after a register write");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_ld))
    else $error("result shown without a load");

  a_rd_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (cnt <= 3'd4))
    else $error("read counter ran past four neighbours");

endmodule

`default_nettype wire

@@ rtl/image_scaler_nearest_bilinear_unit.sv @@
// Top level of the ARGB frame scaler: register port, controller and datapath.
// Depends on imgsc_pkg, imgsc_ctrl and imgsc_dp.
//
// Input transactions on in_valid/in_ready carry op: a store (op 0) writes pixel_in at
// (src_x, src_y) into the frame store and gives no result; a fetch (op 1) returns one
// destination pixel on out_valid/out_ready as pixel_out and size_error.
// A fetch reads the nearest pixel alone, or four neighbours when they are blended:
// the single-port frame store gives one neighbour per cycle. After reset or any
// register write, the first fetch also runs the ratio divider, a bit-serial unit
// doing two or three divisions of 24 quotient bits with the default source limit.
// A fetch with both destination sizes zero goes straight to the output state with
// size_error set; one with a position beyond the destination skips the store reads
// and returns the outside colour.
// Reset restores the register defaults; the frame store is not cleared and must be
// written before it is read. A finished result waits in the output register; the
// next transaction is accepted meanwhile, and a further fetch holds in its final
// state until out_ready frees the register. Registers sit at byte addresses 4*i
// on the APB port; the user must write them only while idle; nothing enforces it.
`timescale 1ns / 1ps
`default_nettype none

module image_scaler_nearest_bilinear_unit
  import imgsc_pkg::*;
#(
  parameter int unsigned MAX_SRC_DIM = MAX_SRC_DIM_D,
  parameter int unsigned MAX_DST_DIM = MAX_DST_DIM_D
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               op,
  input  wire logic [6:0]         src_x,
  input  wire logic [6:0]         src_y,
  input  wire logic [31:0]        pixel_in,
  input  wire logic [11:0]        dst_x,
  input  wire logic [11:0]        dst_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [31:0]        pixel_out,
  output logic                    size_error,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  cfg_t       cfg;
  cmd_t       cmd;
  sts_t       sts;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width      <= 8'd1;
      cfg.src_height     <= 8'd1;
      cfg.dst_width      <= 12'd0;
      cfg.dst_height     <= 12'd0;
      cfg.anti_alias     <= 1'b0;
      cfg.outside_colour <= 32'h00FE_FEFE;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SRC_WIDTH:      cfg.src_width      <= pwdata[7:0];
        REG_SRC_HEIGHT:     cfg.src_height     <= pwdata[7:0];
        REG_DST_WIDTH:      cfg.dst_width      <= pwdata[11:0];
        REG_DST_HEIGHT:     cfg.dst_height     <= pwdata[11:0];
        REG_ANTI_ALIAS:     cfg.anti_alias     <= pwdata[0];
        REG_OUTSIDE_COLOUR: cfg.outside_colour <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SRC_WIDTH:      prdata = 32'(cfg.src_width);
      REG_SRC_HEIGHT:     prdata = 32'(cfg.src_height);
      REG_DST_WIDTH:      prdata = 32'(cfg.dst_width);
      REG_DST_HEIGHT:     prdata = 32'(cfg.dst_height);
      REG_ANTI_ALIAS:     prdata = 32'(cfg.anti_alias);
      REG_OUTSIDE_COLOUR: prdata = cfg.outside_colour;
      default:            prdata = '0;
    endcase
  end

  imgsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cfg_wr   (cfg_wr),
    .sts      (sts),
    .cmd      (cmd)
  );

  imgsc_dp #(
    .MAX_SRC_DIM(MAX_SRC_DIM),
    .MAX_DST_DIM(MAX_DST_DIM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .op        (op),
    .src_x     (src_x),
    .src_y     (src_y),
    .pixel_in  (pixel_in),
    .dst_x     (dst_x),
    .dst_y     (dst_y),
    .pixel_out (pixel_out),
    .size_error(size_error)
  );

endmodule

`default_nettype wire
